FILE: rtl/gfth_pkg.sv
package gfth_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned POS_W   = 5;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned CHI_W   = 32;
  localparam int unsigned NDF_W   = 12;
  localparam int unsigned FTIME_W = 25;
  localparam int unsigned RTIME_W = 21;
  localparam int unsigned RBIN_W  = 15;
  localparam int unsigned CNT_W   = 32;

  // Internal bin width covers the largest supported histogram.
  localparam int unsigned BIN_W   = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHI_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHI_MAX  = 2'd3;

  // Job queue between the classifier and the histogram engine.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // What the back end does with one job.
  typedef enum logic [1:0] {
    OP_REJECT,     // result is all zero
    OP_READ_NULL,  // read outside the store: zero count, echo the bin
    OP_READ,       // read one bin
    OP_ACCUM       // increment one bin
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] position;
    logic [BIN_W-1:0] bin;
  } job_t;

endpackage

FILE: rtl/gfth_if.sv
// Input channel: one fit record or read request per transfer.
interface gfth_in_if;
  import gfth_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [POS_W-1:0]          position;
  logic                      hit;
  logic [TYPE_W-1:0]         fit_type;
  logic [CHI_W-1:0]          chisq;
  logic [NDF_W-1:0]          ndf;
  logic signed [FTIME_W-1:0] fit_time;
  logic                      rf_valid;
  logic signed [RTIME_W-1:0] rf_time;
  logic [RBIN_W-1:0]         read_bin;

  modport source (
    output valid, cmd, position, hit, fit_type, chisq, ndf, fit_time, rf_valid, rf_time,
           read_bin,
    input  ready
  );
  modport sink (
    input  valid, cmd, position, hit, fit_type, chisq, ndf, fit_time, rf_valid, rf_time,
           read_bin,
    output ready
  );
endinterface

// Output channel: one result per transfer.
interface gfth_out_if;
  import gfth_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  count;
  logic              accepted;
  logic [RBIN_W-1:0] bin_index;

  modport source (output valid, count, accepted, bin_index, input ready);
  modport sink (input valid, count, accepted, bin_index, output ready);
endinterface

FILE: rtl/gfth_ram.sv
module gfth_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gfth_queue.sv
module gfth_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gfth_pkg::job_t push_job_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output gfth_pkg::job_t pop_job_o,
  input  logic           pop_i
);
  import gfth_pkg::*;

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = entry_q[rptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_job_i;
    end
  end

  // While the queue is not full, the fill count matches the pointer distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wptr_q - rptr_q) == cnt_q[QPTR_W-1:0]))
    else $error("queue fill count disagrees with pointers");

endmodule

FILE: rtl/gfth_front.sv
module gfth_front #(
  parameter int unsigned DETECTORS = 32,
  parameter int unsigned BINS      = 32768
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  gfth_in_if.sink                             in_i,
  input  logic                                cfg_we_i,
  input  logic [gfth_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gfth_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                hold_i,
  output logic                                push_o,
  output gfth_pkg::job_t                      push_job_o,
  input  logic                                push_ready_i
);
  import gfth_pkg::*;

  localparam int unsigned PROD_W = CHI_W + NDF_W;
  localparam logic signed [31:0] TimeBias = 32'(BINS * 128);
  localparam logic [BIN_W-1:0] BinNoRf   = BIN_W'(BINS - 4);
  localparam logic [BIN_W-1:0] BinLate   = BIN_W'(BINS - 3);
  localparam logic [BIN_W-1:0] BinEarly  = BIN_W'(BINS - 2);

  // Configuration registers.
  logic [TYPE_W-1:0] type_min_q, type_max_q;
  logic [CHI_W-1:0]  chi_min_q, chi_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_min_q <= '0;
      type_max_q <= '1;
      chi_min_q  <= '0;
      chi_max_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TYPE_MIN: type_min_q <= cfg_data_i[TYPE_W-1:0];
        CFG_TYPE_MAX: type_max_q <= cfg_data_i[TYPE_W-1:0];
        CFG_CHI_MIN:  chi_min_q  <= cfg_data_i[CHI_W-1:0];
        CFG_CHI_MAX:  chi_max_q  <= cfg_data_i[CHI_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture stage: fields plus the chi-square window scaled by ndf.
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_cmd_q;
  logic [POS_W-1:0]          s1_pos_q;
  logic                      s1_hit_q;
  logic [TYPE_W-1:0]         s1_type_q;
  logic [CHI_W-1:0]          s1_chisq_q;
  logic [NDF_W-1:0]          s1_ndf_q;
  logic signed [FTIME_W-1:0] s1_ftime_q;
  logic                      s1_rfv_q;
  logic signed [RTIME_W-1:0] s1_rtime_q;
  logic [RBIN_W-1:0]         s1_rbin_q;
  logic [PROD_W-1:0]         s1_lo_q, s1_hi_q;
  logic                      accept;

  assign in_i.ready = !hold_i && (!s1_valid_q || push_ready_i);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= in_i.cmd;
      s1_pos_q   <= in_i.position;
      s1_hit_q   <= in_i.hit;
      s1_type_q  <= in_i.fit_type;
      s1_chisq_q <= in_i.chisq;
      s1_ndf_q   <= in_i.ndf;
      s1_ftime_q <= in_i.fit_time;
      s1_rfv_q   <= in_i.rf_valid;
      s1_rtime_q <= in_i.rf_time;
      s1_rbin_q  <= in_i.read_bin;
      s1_lo_q    <= PROD_W'(chi_min_q) * PROD_W'(in_i.ndf);
      s1_hi_q    <= PROD_W'(chi_max_q) * PROD_W'(in_i.ndf);
    end
  end

  // Time to bin: scale to 1/256 units, round half to even, then clamp.
  logic signed [31:0] t_fix;
  logic signed [23:0] t_floor;
  logic signed [23:0] t_round;
  logic [7:0]         t_frac;
  logic               round_up;
  logic [BIN_W-1:0]   time_bin;

  always_comb begin
    t_fix    = (32'(s1_ftime_q) <<< 4) - (32'(s1_rtime_q) <<< 4) + TimeBias;
    t_floor  = t_fix[31:8];
    t_frac   = t_fix[7:0];
    round_up = (t_frac > 8'd128) || ((t_frac == 8'd128) && t_floor[0]);
    t_round  = t_floor + 24'(round_up);
    if (t_round[23]) begin
      time_bin = BinEarly;
    end else if (t_round[22:0] >= 23'(BINS)) begin
      time_bin = BinLate;
    end else begin
      time_bin = BIN_W'(t_round);
    end
  end

  // Gates and job classification.
  logic pos_ok;
  logic gate_ok;

  always_comb begin
    pos_ok  = (32'(s1_pos_q) < DETECTORS);
    gate_ok = s1_hit_q && (s1_pos_q != '0) && pos_ok && (s1_ndf_q != '0)
              && (s1_type_q >= type_min_q) && (s1_type_q <= type_max_q)
              && (PROD_W'(s1_chisq_q) >= s1_lo_q) && (PROD_W'(s1_chisq_q) <= s1_hi_q);
    push_job_o.position = s1_pos_q;
    if (s1_cmd_q) begin
      push_job_o.bin = BIN_W'(s1_rbin_q);
      push_job_o.op  = (pos_ok && (32'(s1_rbin_q) < BINS)) ? OP_READ : OP_READ_NULL;
    end else if (gate_ok) begin
      push_job_o.bin = s1_rfv_q ? time_bin : BinNoRf;
      push_job_o.op  = OP_ACCUM;
    end else begin
      push_job_o.bin = '0;
      push_job_o.op  = OP_REJECT;
    end
  end

  assign push_o = s1_valid_q;

endmodule

FILE: rtl/gfth_back.sv
module gfth_back #(
  parameter int unsigned DETECTORS = 32,
  parameter int unsigned BINS      = 32768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  gfth_pkg::job_t job_i,
  output logic           pop_o,
  output logic           clearing_o,
  gfth_out_if.source     out_o
);
  import gfth_pkg::*;

  localparam int unsigned Depth = DETECTORS * BINS;
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] addr_q, head_addr;
  job_t             job_q;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  logic             slot_free;
  logic             load;
  logic [CNT_W-1:0] load_count;
  logic             load_acc;
  logic [BIN_W-1:0] load_bin;
  logic [CNT_W-1:0] bumped;

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_count_q;
  logic             out_acc_q;
  logic [RBIN_W-1:0] out_bin_q;

  gfth_ram #(
    .Width (CNT_W),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_addr),
    .rdata_o (ram_rdata)
  );

  assign head_addr = AddrW'(32'(job_i.position) * BINS + 32'(job_i.bin));
  assign slot_free = !out_valid_q || out_o.ready;
  assign bumped    = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign clearing_o = (state_q == ST_CLEAR);

  // Sequencer: clear pass, then per job read one bin and write it back for an update.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pop_o      = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = bumped;
    load       = 1'b0;
    load_count = '0;
    load_acc   = 1'b0;
    load_bin   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.op)
            OP_READ, OP_ACCUM: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              state_d = ST_DATA;
            end
            OP_READ_NULL: begin
              if (slot_free) begin
                pop_o    = 1'b1;
                load     = 1'b1;
                load_bin = job_i.bin;
              end
            end
            default: begin
              if (slot_free) begin
                pop_o = 1'b1;
                load  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          load     = 1'b1;
          load_bin = job_q.bin;
          if (job_q.op == OP_ACCUM) begin
            ram_we     = 1'b1;
            load_count = bumped;
            load_acc   = 1'b1;
          end else begin
            load_count = ram_rdata;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      job_q  <= job_i;
      addr_q <= head_addr;
    end
  end

  // Output register decouples the engine from the result channel.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_count_q <= load_count;
      out_acc_q   <= load_acc;
      out_bin_q   <= load_bin[RBIN_W-1:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.count     = out_count_q;
  assign out_o.accepted  = out_acc_q;
  assign out_o.bin_index = out_bin_q;

  // No job leaves the queue during the clear pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o)
    else $error("job taken during clear pass");

  // A memory read is always followed by its data phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == ST_DATA))
    else $error("memory read without data phase");

  // Outside the clear pass only an update writes the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != ST_CLEAR)) |-> (job_q.op == OP_ACCUM))
    else $error("store written by a non-update job");

  // An update result never reports a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_acc) |=> (out_count_q != '0))
    else $error("update result with zero count");

endmodule

FILE: rtl/gated_fit_time_histogrammer.sv
// Gated fit-time histogrammer. Fit records are gated on hit, position, fit type
// and chi-square per degree of freedom; accepted records increment one bin of
// their detector's time histogram (DETECTORS x BINS counts of 32 bits, saturating),
// and read requests return one bin. After reset the block runs a clear pass over
// all DETECTORS*BINS counts during which in_i.ready stays low; configuration
// writes are taken at any time. The front end takes one item per cycle, while
// the downstream path is not stalled, into a four-entry job queue. The back end
// handles a histogram update or read in an IDLE state that issues the memory
// read and a DATA state that returns the count and, for an update, writes the
// saturated increment back; a rejected record or a read outside the store is
// answered from IDLE without a memory access. A new memory job is not taken
// before the DATA state of the last one has finished.
module gated_fit_time_histogrammer #(
  parameter int unsigned DETECTORS = 32,
  parameter int unsigned BINS      = 32768
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gfth_in_if.sink                         in_i,
  gfth_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [gfth_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gfth_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gfth_pkg::*;

  logic push, push_ready;
  job_t push_job;
  logic pop_valid, pop;
  job_t pop_job;
  logic clearing;

  gfth_front #(
    .DETECTORS (DETECTORS),
    .BINS      (BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .hold_i       (clearing),
    .push_o       (push),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  gfth_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_i        (pop)
  );

  gfth_back #(
    .DETECTORS (DETECTORS),
    .BINS      (BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule
